// ----- rtl/xxh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh_pkg
// Constants, types and helpers shared by the dual-seed xxh64 hasher.
// ----------------------------------------------------------------------------
package xxh_pkg;

	localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
	localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] P3 = 64'h165667B19E3779F9;
	localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
	localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

	localparam int unsigned CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_A = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_B = 4'd1;

	// classified message word, as held in the front queue
	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  n;
		logic        full;
		logic        last;
	} item_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] p;
	} mul_rsp_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_ACC_M1,
		B_ACC_M2,
		B_FIN_INIT,
		B_FV_M1,
		B_FV_M2,
		B_FV_M3,
		B_FP_M1,
		B_FP_M2,
		B_FP_M3,
		B_FT_M1,
		B_FT_M2,
		B_AV_M1,
		B_AV_M2,
		B_OUT
	} back_state_t;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
		return (x << r) | (x >> (64 - r));
	endfunction

endpackage

// ----- rtl/xxh_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh_in_if
// Message word channel: one beat carries one little-endian 64-bit word.
// ----------------------------------------------------------------------------
interface xxh_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  valid_bytes;
	logic        last;

	modport source (output valid, output data_word, output valid_bytes, output last,
		input ready);
	modport sink (input valid, input data_word, input valid_bytes, input last,
		output ready);
endinterface

// ----- rtl/xxh_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh_out_if
// Digest channel: one beat per finished message.
// ----------------------------------------------------------------------------
interface xxh_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_a;
	logic [63:0] digest_b;
	logic [63:0] digest_mixed;

	modport source (output valid, output digest_a, output digest_b, output digest_mixed,
		input ready);
	modport sink (input valid, input digest_a, input digest_b, input digest_mixed,
		output ready);
endinterface

// ----- rtl/xxh_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh_cfg_if
// Register write channel: one beat writes one register.
// ----------------------------------------------------------------------------
interface xxh_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [xxh_pkg::CFG_IDX_W-1:0]  index;
	logic [63:0]                    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/xxh64_dual_seed_hasher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh64_dual_seed_hasher
// XXH64 of a word stream under two seeds, plus the XOR of both digests.
// ----------------------------------------------------------------------------
// A word that does not close a 32-byte stripe and is not last is only stored;
// the word that closes a stripe runs all eight accumulator updates, two
// multiplies each, through one shared 64-bit multiplier that builds each
// product from three 32 x 32 partial products in turn. The last word of a
// message adds the finish of both lanes, up to about 37 products per lane.
// A two-beat queue in front keeps taking words while the back end works, and
// the digest register holds a result while the next message is already
// started.
module xxh64_dual_seed_hasher (
	input  logic      clk,
	input  logic      arst_n,
	xxh_in_if.sink    msg,
	xxh_out_if.source res,
	xxh_cfg_if.sink   cfg
);

	logic [63:0]    seed_a_q;
	logic [63:0]    seed_b_q;
	xxh_pkg::item_t item;
	logic           item_valid;
	logic           item_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_a_q <= 64'd0;
			seed_b_q <= xxh_pkg::P1;
		end else if (cfg.valid) begin
			case (cfg.index)
				xxh_pkg::REG_SEED_A: seed_a_q <= cfg.data;
				xxh_pkg::REG_SEED_B: seed_b_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	xxh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready)
	);

	xxh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.seed_a     (seed_a_q),
		.seed_b     (seed_b_q),
		.res        (res)
	);

endmodule

// ----- rtl/xxh_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh_front
// Accepts message words, sizes and masks them, and queues them for the back.
// ----------------------------------------------------------------------------
module xxh_front (
	input  logic           clk,
	input  logic           arst_n,
	xxh_in_if.sink         msg,
	output xxh_pkg::item_t item,
	output logic           item_valid,
	input  logic           item_ready
);

	xxh_pkg::item_t q_mem [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	logic           push;
	logic           pop;
	logic [3:0]     nb;
	logic [6:0]     sh;
	xxh_pkg::item_t cls;

	// a word that is not last always counts as eight bytes
	always_comb begin
		if (!msg.last) begin
			nb = 4'd8;
		end else if (msg.valid_bytes > 4'd8) begin
			nb = 4'd8;
		end else begin
			nb = msg.valid_bytes;
		end
		sh = 7'd64 - {nb, 3'b000};
		cls.n = nb;
		cls.full = (nb == 4'd8);
		cls.last = msg.last;
		cls.word = cls.full ? msg.data_word : (msg.data_word & ({64{1'b1}} >> sh));
	end

	assign msg.ready = (count_q != 2'd2);
	assign push = msg.valid && msg.ready;
	assign item_valid = (count_q != 2'd0);
	assign pop = item_valid && item_ready;
	assign item = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/xxh_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh_mul
// 64 x 64 multiplier, low half only, three 32 x 32 partial products in turn.
// ----------------------------------------------------------------------------
module xxh_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  xxh_pkg::mul_req_t req,
	output xxh_pkg::mul_rsp_t rsp
);

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] p_q;
	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;

	logic [31:0] ma;
	logic [31:0] mb;
	logic [63:0] mprod;

	always_comb begin
		case (step_q)
			2'd0: begin
				ma = a_q[31:0];
				mb = b_q[31:0];
			end
			2'd1: begin
				ma = a_q[31:0];
				mb = b_q[63:32];
			end
			default: begin
				ma = a_q[63:32];
				mb = b_q[31:0];
			end
		endcase
		mprod = {32'd0, ma} * {32'd0, mb};
	end

	assign rsp.done = done_q;
	assign rsp.p = p_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		if (busy_q) begin
			case (step_q)
				2'd0: p_q <= mprod;
				default: p_q <= p_q + {mprod[31:0], 32'd0};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					step_q <= 2'd0;
				end else begin
					step_q <= step_q + 2'd1;
				end
			end
		end
	end

endmodule

// ----- rtl/xxh_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh_back
// Stripe absorb, lane finish and avalanche, sequenced over one shared multiplier.
// ----------------------------------------------------------------------------
module xxh_back (
	input  logic           clk,
	input  logic           arst_n,
	input  xxh_pkg::item_t item,
	input  logic           item_valid,
	output logic           item_ready,
	input  logic [63:0]    seed_a,
	input  logic [63:0]    seed_b,
	xxh_out_if.source      res
);

	xxh_pkg::back_state_t state_q;
	xxh_pkg::back_state_t state_d;

	logic [63:0] acc_q [8];
	logic [63:0] pw_q [4];
	logic [2:0]  cnt_q;
	logic [63:0] len_q;
	logic [63:0] tailw_q;
	logic [3:0]  tailn_q;
	logic        last_q;
	logic        lane_q;
	logic [2:0]  idx_q;
	logic        issued_q;
	logic [63:0] h_q;
	logic [63:0] t_q;
	logic [63:0] dig_a_q;
	logic        out_v_q;
	logic [63:0] out_a_q;
	logic [63:0] out_b_q;
	logic [63:0] out_m_q;

	xxh_pkg::mul_req_t    mreq;
	xxh_pkg::mul_rsp_t    mrsp;
	xxh_pkg::back_state_t after_h;

	logic [2:0]  acc_ri;
	logic [63:0] acc_rd;
	logic [63:0] pw_rd;
	logic [63:0] seed;
	logic [63:0] v0, v1, v2, v3;
	logic [7:0]  tail_byte;
	logic        long_msg;
	logic        mul_state;
	logic        mdone;
	logic        out_free;
	logic [63:0] len_full;

	xxh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	assign mdone = mrsp.done;
	assign acc_ri = (state_q == xxh_pkg::B_FV_M1) ? {lane_q, idx_q[1:0]} : idx_q;
	assign acc_rd = acc_q[acc_ri];
	assign pw_rd = pw_q[idx_q[1:0]];
	assign seed = lane_q ? seed_b : seed_a;
	assign v0 = lane_q ? acc_q[4] : acc_q[0];
	assign v1 = lane_q ? acc_q[5] : acc_q[1];
	assign v2 = lane_q ? acc_q[6] : acc_q[2];
	assign v3 = lane_q ? acc_q[7] : acc_q[3];
	assign tail_byte = tailw_q[{idx_q, 3'b000} +: 8];
	assign long_msg = (len_q >= 64'd32);
	assign out_free = !out_v_q || res.ready;
	assign len_full = len_q + 64'd8;

	// where the finish goes once the start value and length are in
	always_comb begin
		if (cnt_q != 3'd0) begin
			after_h = xxh_pkg::B_FP_M1;
		end else if (tailn_q != 4'd0) begin
			after_h = xxh_pkg::B_FT_M1;
		end else begin
			after_h = xxh_pkg::B_AV_M1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			xxh_pkg::B_IDLE: begin
				if (item_valid) begin
					if (item.full && cnt_q == 3'd3) begin
						state_d = xxh_pkg::B_ACC_M1;
					end else if (item.last) begin
						state_d = xxh_pkg::B_FIN_INIT;
					end
				end
			end
			xxh_pkg::B_ACC_M1: if (mdone) state_d = xxh_pkg::B_ACC_M2;
			xxh_pkg::B_ACC_M2: begin
				if (mdone) begin
					if (idx_q == 3'd7) begin
						state_d = last_q ? xxh_pkg::B_FIN_INIT : xxh_pkg::B_IDLE;
					end else begin
						state_d = xxh_pkg::B_ACC_M1;
					end
				end
			end
			xxh_pkg::B_FIN_INIT: state_d = long_msg ? xxh_pkg::B_FV_M1 : after_h;
			xxh_pkg::B_FV_M1: if (mdone) state_d = xxh_pkg::B_FV_M2;
			xxh_pkg::B_FV_M2: if (mdone) state_d = xxh_pkg::B_FV_M3;
			xxh_pkg::B_FV_M3: begin
				if (mdone) begin
					state_d = (idx_q == 3'd3) ? after_h : xxh_pkg::B_FV_M1;
				end
			end
			xxh_pkg::B_FP_M1: if (mdone) state_d = xxh_pkg::B_FP_M2;
			xxh_pkg::B_FP_M2: if (mdone) state_d = xxh_pkg::B_FP_M3;
			xxh_pkg::B_FP_M3: begin
				if (mdone) begin
					if (idx_q + 3'd1 == cnt_q) begin
						state_d = (tailn_q != 4'd0) ? xxh_pkg::B_FT_M1 : xxh_pkg::B_AV_M1;
					end else begin
						state_d = xxh_pkg::B_FP_M1;
					end
				end
			end
			xxh_pkg::B_FT_M1: if (mdone) state_d = xxh_pkg::B_FT_M2;
			xxh_pkg::B_FT_M2: begin
				if (mdone) begin
					state_d = ({1'b0, idx_q} + 4'd1 == tailn_q) ? xxh_pkg::B_AV_M1
						: xxh_pkg::B_FT_M1;
				end
			end
			xxh_pkg::B_AV_M1: if (mdone) state_d = xxh_pkg::B_AV_M2;
			xxh_pkg::B_AV_M2: begin
				if (mdone) begin
					state_d = lane_q ? xxh_pkg::B_OUT : xxh_pkg::B_FIN_INIT;
				end
			end
			xxh_pkg::B_OUT: if (out_free) state_d = xxh_pkg::B_IDLE;
			default: state_d = xxh_pkg::B_IDLE;
		endcase
	end

	// outputs: pop strobe and multiplier operands
	always_comb begin
		item_ready = (state_q == xxh_pkg::B_IDLE);
		mul_state = 1'b1;
		mreq.a = t_q;
		mreq.b = xxh_pkg::P1;
		case (state_q)
			xxh_pkg::B_ACC_M1: begin
				mreq.a = pw_rd;
				mreq.b = xxh_pkg::P2;
			end
			xxh_pkg::B_ACC_M2, xxh_pkg::B_FV_M2, xxh_pkg::B_FP_M2: begin
				mreq.a = t_q;
				mreq.b = xxh_pkg::P1;
			end
			xxh_pkg::B_FV_M1: begin
				mreq.a = acc_rd;
				mreq.b = xxh_pkg::P2;
			end
			xxh_pkg::B_FV_M3: begin
				mreq.a = h_q;
				mreq.b = xxh_pkg::P1;
			end
			xxh_pkg::B_FP_M1: begin
				mreq.a = pw_rd;
				mreq.b = xxh_pkg::P2;
			end
			xxh_pkg::B_FP_M3: begin
				mreq.a = xxh_pkg::rotl64(h_q, 27);
				mreq.b = xxh_pkg::P1;
			end
			xxh_pkg::B_FT_M1: begin
				mreq.a = {56'd0, tail_byte};
				mreq.b = xxh_pkg::P5;
			end
			xxh_pkg::B_FT_M2: begin
				mreq.a = xxh_pkg::rotl64(h_q, 11);
				mreq.b = xxh_pkg::P1;
			end
			xxh_pkg::B_AV_M1: begin
				mreq.a = h_q ^ (h_q >> 33);
				mreq.b = xxh_pkg::P2;
			end
			xxh_pkg::B_AV_M2: begin
				mreq.a = h_q;
				mreq.b = xxh_pkg::P3;
			end
			default: mul_state = 1'b0;
		endcase
		mreq.start = mul_state && !issued_q;
	end

	assign res.valid = out_v_q;
	assign res.digest_a = out_a_q;
	assign res.digest_b = out_b_q;
	assign res.digest_mixed = out_m_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xxh_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			xxh_pkg::B_IDLE: begin
				if (item_valid) begin
					if (item.full) begin
						pw_q[cnt_q[1:0]] <= item.word;
						tailw_q <= 64'd0;
					end else begin
						tailw_q <= item.word;
					end
				end
			end
			xxh_pkg::B_ACC_M1, xxh_pkg::B_FV_M1, xxh_pkg::B_FP_M1: begin
				if (mdone) begin
					t_q <= (state_q == xxh_pkg::B_ACC_M1) ? xxh_pkg::rotl64(acc_rd + mrsp.p, 31)
						: xxh_pkg::rotl64(mrsp.p, 31);
				end
			end
			xxh_pkg::B_FIN_INIT: begin
				if (long_msg) begin
					h_q <= xxh_pkg::rotl64(v0, 1) + xxh_pkg::rotl64(v1, 7)
						+ xxh_pkg::rotl64(v2, 12) + xxh_pkg::rotl64(v3, 18);
				end else begin
					h_q <= seed + xxh_pkg::P5 + len_q;
				end
			end
			xxh_pkg::B_FV_M2, xxh_pkg::B_FP_M2, xxh_pkg::B_FT_M1: begin
				if (mdone) h_q <= h_q ^ mrsp.p;
			end
			xxh_pkg::B_FV_M3: begin
				if (mdone) begin
					h_q <= (idx_q == 3'd3) ? (mrsp.p + xxh_pkg::P4 + len_q)
						: (mrsp.p + xxh_pkg::P4);
				end
			end
			xxh_pkg::B_FP_M3: if (mdone) h_q <= mrsp.p + xxh_pkg::P4;
			xxh_pkg::B_FT_M2: if (mdone) h_q <= mrsp.p;
			xxh_pkg::B_AV_M1: if (mdone) h_q <= mrsp.p ^ (mrsp.p >> 29);
			xxh_pkg::B_AV_M2: begin
				if (mdone) begin
					h_q <= mrsp.p ^ (mrsp.p >> 32);
					if (!lane_q) dig_a_q <= mrsp.p ^ (mrsp.p >> 32);
				end
			end
			xxh_pkg::B_OUT: begin
				if (out_free) begin
					out_a_q <= dig_a_q;
					out_b_q <= h_q;
					out_m_q <= dig_a_q ^ h_q;
				end
			end
			default: begin
			end
		endcase
	end

	// control registers and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q[0] <= xxh_pkg::P1 + xxh_pkg::P2;
			acc_q[1] <= xxh_pkg::P2;
			acc_q[2] <= 64'd0;
			acc_q[3] <= 64'd0 - xxh_pkg::P1;
			acc_q[4] <= xxh_pkg::P1 + xxh_pkg::P1 + xxh_pkg::P2;
			acc_q[5] <= xxh_pkg::P1 + xxh_pkg::P2;
			acc_q[6] <= xxh_pkg::P1;
			acc_q[7] <= 64'd0;
			cnt_q <= 3'd0;
			len_q <= 64'd0;
			tailn_q <= 4'd0;
			last_q <= 1'b0;
			lane_q <= 1'b0;
			idx_q <= 3'd0;
			issued_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (mreq.start) begin
				issued_q <= 1'b1;
			end else if (mdone) begin
				issued_q <= 1'b0;
			end
			if (res.valid && res.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				xxh_pkg::B_IDLE: begin
					if (item_valid) begin
						last_q <= item.last;
						lane_q <= 1'b0;
						idx_q <= 3'd0;
						if (item.full) begin
							len_q <= len_full;
							tailn_q <= 4'd0;
							if (cnt_q == 3'd3) begin
								cnt_q <= 3'd0;
								// first stripe of a message takes the current seeds
								if (len_full == 64'd32) begin
									acc_q[0] <= seed_a + xxh_pkg::P1 + xxh_pkg::P2;
									acc_q[1] <= seed_a + xxh_pkg::P2;
									acc_q[2] <= seed_a;
									acc_q[3] <= seed_a - xxh_pkg::P1;
									acc_q[4] <= seed_b + xxh_pkg::P1 + xxh_pkg::P2;
									acc_q[5] <= seed_b + xxh_pkg::P2;
									acc_q[6] <= seed_b;
									acc_q[7] <= seed_b - xxh_pkg::P1;
								end
							end else begin
								cnt_q <= cnt_q + 3'd1;
							end
						end else begin
							len_q <= len_q + {60'd0, item.n};
							tailn_q <= item.n;
						end
					end
				end
				xxh_pkg::B_ACC_M2: begin
					if (mdone) begin
						acc_q[idx_q] <= mrsp.p;
						idx_q <= idx_q + 3'd1;
					end
				end
				xxh_pkg::B_FIN_INIT: idx_q <= 3'd0;
				xxh_pkg::B_FV_M3, xxh_pkg::B_FP_M3: begin
					if (mdone) begin
						if ((state_q == xxh_pkg::B_FV_M3 && idx_q == 3'd3)
							|| (state_q == xxh_pkg::B_FP_M3 && idx_q + 3'd1 == cnt_q)) begin
							idx_q <= 3'd0;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				xxh_pkg::B_FT_M2: if (mdone) idx_q <= idx_q + 3'd1;
				xxh_pkg::B_AV_M2: if (mdone) lane_q <= 1'b1;
				xxh_pkg::B_OUT: begin
					if (out_free) begin
						out_v_q <= 1'b1;
						cnt_q <= 3'd0;
						len_q <= 64'd0;
						tailn_q <= 4'd0;
						lane_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dual-seed xxh64 hasher. A short table of
// messages covers the edges of the word format, then random messages of mixed
// length run under several seed settings and idle patterns. Every digest beat
// is compared with a bit-exact model of both lanes (empty message: known lane A).
// ----------------------------------------------------------------------------
module tb;
	import xxh_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int unsigned DRAIN_CYCLES   = 500;
	localparam int unsigned RANDOM_ITEMS   = 400;

	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] m;
	} digest_t;

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  vb;
		logic        lst;
		logic        known;
		logic [63:0] known_a;
	} stim_row_t;

	logic clk;
	logic arst_n;

	xxh_in_if  msg_if ();
	xxh_out_if res_if ();
	xxh_cfg_if cfg_if ();

	xxh64_dual_seed_hasher i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	// bench copy of the hasher state
	logic [63:0] seed_a_q;
	logic [63:0] seed_b_q;
	logic [63:0] lane_acc [8];
	logic [63:0] held_words [4];
	int unsigned held_count;
	logic [63:0] msg_length;

	digest_t digests_due [$];
	int unsigned errors;
	int unsigned gap_pct;
	int unsigned stall_pct;
	int unsigned idle_cycles;
	int unsigned items_sent;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic [63:0] rot_left(input logic [63:0] x, input int unsigned r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic logic [63:0] acc_round(input logic [63:0] acc, input logic [63:0] w);
		return rot_left(acc + w * P2, 31) * P1;
	endfunction

	task automatic seed_lanes();
		lane_acc[0] = seed_a_q + P1 + P2;
		lane_acc[1] = seed_a_q + P2;
		lane_acc[2] = seed_a_q;
		lane_acc[3] = seed_a_q - P1;
		lane_acc[4] = seed_b_q + P1 + P2;
		lane_acc[5] = seed_b_q + P2;
		lane_acc[6] = seed_b_q;
		lane_acc[7] = seed_b_q - P1;
	endtask

	function automatic logic [63:0] lane_digest(input int unsigned base, input logic [63:0] seed,
		input logic [63:0] tailw, input int unsigned tailn);
		logic [63:0] h;
		if (msg_length >= 64'd32) begin
			h = rot_left(lane_acc[base], 1) + rot_left(lane_acc[base+1], 7)
				+ rot_left(lane_acc[base+2], 12) + rot_left(lane_acc[base+3], 18);
			for (int i = 0; i < 4; i++) begin
				h = h ^ acc_round(64'd0, lane_acc[base+i]);
				h = h * P1 + P4;
			end
		end else begin
			h = seed + P5;
		end
		h = h + msg_length;
		for (int i = 0; i < held_count; i++) begin
			h = h ^ acc_round(64'd0, held_words[i]);
			h = rot_left(h, 27) * P1 + P4;
		end
		for (int i = 0; i < tailn; i++) begin
			h = h ^ (((tailw >> (8 * i)) & 64'hFF) * P5);
			h = rot_left(h, 11) * P1;
		end
		h = h ^ (h >> 33);
		h = h * P2;
		h = h ^ (h >> 29);
		h = h * P3;
		h = h ^ (h >> 32);
		return h;
	endfunction

	// absorb one accepted word; returns 1 with the digests when it ends a message
	task automatic hash_word(input logic [63:0] w, input logic [3:0] vb, input logic lst,
		output bit done, output digest_t d);
		int unsigned n;
		logic [63:0] tailw;
		n = !lst ? 8 : (vb > 4'd8 ? 8 : int'(vb));
		tailw = '0;
		done = 1'b0;
		d = '0;
		if (n == 8) begin
			held_words[held_count] = w;
			held_count++;
			msg_length = msg_length + 64'd8;
			if (held_count == 4) begin
				if (msg_length == 64'd32)
					seed_lanes();
				for (int i = 0; i < 4; i++) begin
					lane_acc[i]   = acc_round(lane_acc[i], held_words[i]);
					lane_acc[4+i] = acc_round(lane_acc[4+i], held_words[i]);
				end
				held_count = 0;
			end
			n = 0;
		end else begin
			msg_length = msg_length + 64'(n);
			tailw = (n == 0) ? 64'd0 : (w & (~64'd0 >> (64 - 8 * n)));
		end
		if (lst) begin
			d.a = lane_digest(0, seed_a_q, tailw, n);
			d.b = lane_digest(4, seed_b_q, tailw, n);
			d.m = d.a ^ d.b;
			done = 1'b1;
			held_count = 0;
			msg_length = '0;
		end
	endtask

	task automatic send_word(input logic [63:0] w, input logic [3:0] vb, input logic lst,
		input logic known, input logic [63:0] known_a);
		bit done;
		digest_t d;
		while ($urandom_range(0, 99) < gap_pct) begin
			msg_if.valid <= 1'b0;
			@(posedge clk);
		end
		msg_if.valid       <= 1'b1;
		msg_if.data_word   <= w;
		msg_if.valid_bytes <= vb;
		msg_if.last        <= lst;
		@(posedge clk);
		while (!msg_if.ready)
			@(posedge clk);
		items_sent++;
		hash_word(w, vb, lst, done, d);
		if (done) begin
			if (known) begin
				d.a = known_a;
				d.m = d.a ^ d.b;
			end
			digests_due.push_back(d);
		end
	endtask

	task automatic wait_drained();
		msg_if.valid <= 1'b0;
		@(posedge clk);
		while (digests_due.size() != 0)
			@(posedge clk);
	endtask

	// only called with no message open; waits out any word still in the back end
	task automatic write_seed(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		if (idx == REG_SEED_A)
			seed_a_q = value;
		else
			seed_b_q = value;
	endtask

	task automatic random_message();
		int unsigned words;
		logic [63:0] w;
		logic [3:0] vb;
		words = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
		for (int i = 0; i <= words; i++) begin
			case ($urandom_range(0, 9))
				0: w = '0;
				1: w = '1;
				default: w = {$urandom, $urandom};
			endcase
			if (i < words) begin
				send_word(w, 4'($urandom_range(0, 15)), 1'b0, 1'b0, '0);
			end else begin
				vb = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
					: 4'($urandom_range(0, 8));
				send_word(w, vb, 1'b1, 1'b0, '0);
			end
		end
	endtask

	task automatic random_phase(input int unsigned gap, input int unsigned stall,
		input bit hold_off);
		int unsigned target;
		gap_pct = gap;
		stall_pct = stall;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			random_message();
			// sender holds off until the digest pipe is empty
			if (hold_off && $urandom_range(0, 9) == 0)
				wait_drained();
		end
	endtask

	stim_row_t directed [20] = '{
		'{64'h0, 4'd0, 1'b1, 1'b1, 64'hEF46DB3751D8E999},   // empty message
		'{64'hA5, 4'd1, 1'b1, 1'b0, 64'h0},
		'{64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b1, 1'b0, 64'h0},
		'{64'hFFFFFFFFFFFFFFFF, 4'd15, 1'b1, 1'b0, 64'h0},  // saturates to eight bytes
		'{64'hDEADBEEFCAFEF00D, 4'd3, 1'b1, 1'b0, 64'h0},   // upper bytes ignored
		'{64'h0123456789ABCDEF, 4'd5, 1'b0, 1'b0, 64'h0},   // count ignored when not last
		'{64'hFEDCBA9876543210, 4'd0, 1'b1, 1'b0, 64'h0},
		'{64'h1111111111111111, 4'd8, 1'b0, 1'b0, 64'h0},
		'{64'h2222222222222222, 4'd8, 1'b0, 1'b0, 64'h0},
		'{64'h3333333333333333, 4'd8, 1'b0, 1'b0, 64'h0},
		'{64'h4444444444444444, 4'd8, 1'b0, 1'b0, 64'h0},
		'{64'h0, 4'd0, 1'b1, 1'b0, 64'h0},                  // exactly one stripe
		'{64'h8000000000000001, 4'd8, 1'b0, 1'b0, 64'h0},
		'{64'h7FFFFFFFFFFFFFFE, 4'd8, 1'b0, 1'b0, 64'h0},
		'{64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b0, 1'b0, 64'h0},
		'{64'h0, 4'd8, 1'b0, 1'b0, 64'h0},
		'{64'h5A5A5A5A5A5A5A5A, 4'd8, 1'b0, 1'b0, 64'h0},
		'{64'hC3C3C3C3C3C3C3C3, 4'd8, 1'b0, 1'b0, 64'h0},
		'{64'h0F0F0F0F0F0F0F0F, 4'd8, 1'b0, 1'b0, 64'h0},
		'{64'hAAAAAAAAAAAAAAAA, 4'd7, 1'b1, 1'b0, 64'h0}    // stripe, held words, tail
	};

	always @(posedge clk) begin
		if (!arst_n)
			res_if.ready <= 1'b0;
		else
			res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// digest checker
	always @(posedge clk) begin
		digest_t d;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (digests_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected digest beat a=%h b=%h", res_if.digest_a,
						res_if.digest_b);
			end else begin
				d = digests_due.pop_front();
				if (res_if.digest_a !== d.a || res_if.digest_b !== d.b
					|| res_if.digest_mixed !== d.m) begin
					errors++;
					if (errors <= 10)
						$display("digest mismatch: exp a=%h b=%h m=%h got a=%h b=%h m=%h",
							d.a, d.b, d.m, res_if.digest_a, res_if.digest_b,
							res_if.digest_mixed);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (msg_if.valid && msg_if.ready) || (res_if.valid && res_if.ready)
			|| (cfg_if.valid && cfg_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		errors = 0;
		items_sent = 0;
		idle_cycles = 0;
		gap_pct = 0;
		stall_pct = 0;
		seed_a_q = '0;
		seed_b_q = P1;
		seed_lanes();
		held_count = 0;
		msg_length = '0;
		arst_n = 1'b0;
		msg_if.valid       <= 1'b0;
		msg_if.data_word   <= '0;
		msg_if.valid_bytes <= '0;
		msg_if.last        <= 1'b0;
		cfg_if.valid       <= 1'b0;
		cfg_if.index       <= REG_SEED_A;
		cfg_if.data        <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_word(directed[i].word, directed[i].vb, directed[i].lst, directed[i].known,
				directed[i].known_a);
		random_phase(0, 0, 1'b0);

		write_seed(REG_SEED_A, 64'hFFFFFFFFFFFFFFFF);
		write_seed(REG_SEED_B, 64'h0);
		random_phase(52, 0, 1'b1);

		write_seed(REG_SEED_A, 64'h0);
		write_seed(REG_SEED_B, 64'hFFFFFFFFFFFFFFFF);
		random_phase(0, 52, 1'b0);

		write_seed(REG_SEED_A, {$urandom, $urandom});
		write_seed(REG_SEED_B, {$urandom, $urandom});
		random_phase(14, 14, 1'b0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/xxh_pkg.sv
rtl/xxh_in_if.sv
rtl/xxh_out_if.sv
rtl/xxh_cfg_if.sv
rtl/xxh_front.sv
rtl/xxh_mul.sv
rtl/xxh_back.sv
rtl/xxh64_dual_seed_hasher.sv
tb/sv/tb.sv
